FILE: rtl/core/periodic_run_length_word_checker_macros.svh
// Assertion macros for the checker's modules; the scanner uses them.
`ifndef PERIODIC_RUN_LENGTH_WORD_CHECKER_MACROS_SVH
`define PERIODIC_RUN_LENGTH_WORD_CHECKER_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define PRLW_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// When the condition holds, the consequence must hold in the same cycle.
`define PRLW_ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("%m: same-cycle implication violated");

// When the condition holds, the consequence must hold in the next cycle.
`define PRLW_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("%m: next-cycle implication violated");

`endif

FILE: rtl/core/prlw_pkg.sv
`timescale 1ns / 1ps

package prlw_pkg;

   // Width of every run counter; runs saturate at the all-ones value.
   localparam int COUNT_WIDTH = 16;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam count_type COUNT_ONE = count_type'(1);

   // Character codes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] BLANK_LOW  = 8'h09;
   localparam logic [7:0] BLANK_HIGH = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Scanner states, one-hot.
   typedef enum logic [5:0] {
      MODE_IDLE       = 6'b000001,
      MODE_FIRST_ZERO = 6'b000010,
      MODE_FIRST_ONE  = 6'b000100,
      MODE_CHECK_ZERO = 6'b001000,
      MODE_CHECK_ONE  = 6'b010000,
      MODE_SKIP       = 6'b100000
   } mode_type;

   // One input word as it travels from the input register to the scanner.
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_stream;
   } item_type;

   // What the scanner produces for one word.
   typedef struct packed {
      logic present;
      logic verdict;
   } result_type;

   // True for tab, line feed, vertical tab, form feed, carriage return and space.
   function automatic logic is_blank(input logic [7:0] c);
      return ((c >= BLANK_LOW) && (c <= BLANK_HIGH)) || (c == CHAR_SPACE);
   endfunction

   // Increment that stops at the counter's maximum.
   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? COUNT_MAX : count_type'(v + COUNT_ONE);
   endfunction

endpackage

FILE: rtl/core/prlw_in_stage.sv
`timescale 1ns / 1ps

module prlw_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_stream,
   output prlw_pkg::item_type item,
   output logic               item_valid,
   input  logic               item_take
);

   logic               valid_ff;
   logic               valid_in;
   prlw_pkg::item_type item_ff;
   logic               load;

   // The register accepts a new word when empty or when its word leaves this cycle.
   assign req_ready = !valid_ff || item_take;
   assign load      = req_valid && req_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.char_code     <= req_char_code;
         item_ff.end_of_stream <= req_end_of_stream;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

FILE: rtl/core/prlw_scan.sv
`timescale 1ns / 1ps
`include "periodic_run_length_word_checker_macros.svh"

module prlw_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  prlw_pkg::item_type   item,
   output prlw_pkg::result_type result
);

   prlw_pkg::mode_type  mode_ff;
   prlw_pkg::mode_type  mode_in;
   prlw_pkg::mode_type  mode_cur;
   prlw_pkg::count_type first_zero_ff;
   prlw_pkg::count_type first_zero_in;
   prlw_pkg::count_type first_one_ff;
   prlw_pkg::count_type first_one_in;
   prlw_pkg::count_type cur_zero_ff;
   prlw_pkg::count_type cur_zero_in;
   prlw_pkg::count_type cur_one_ff;
   prlw_pkg::count_type cur_one_in;
   logic                word_end;
   logic                is_zero;
   logic                is_one;
   logic                reject_hit;
   logic                zero_match;
   logic                one_match;

   // Unused state codes behave as idle.
   always_comb begin
      unique case (mode_ff)
         prlw_pkg::MODE_IDLE,
         prlw_pkg::MODE_FIRST_ZERO,
         prlw_pkg::MODE_FIRST_ONE,
         prlw_pkg::MODE_CHECK_ZERO,
         prlw_pkg::MODE_CHECK_ONE,
         prlw_pkg::MODE_SKIP: mode_cur = mode_ff;
         default: mode_cur = prlw_pkg::MODE_IDLE;
      endcase
   end

   assign word_end   = item.end_of_stream || prlw_pkg::is_blank(item.char_code);
   assign is_zero    = (item.char_code == prlw_pkg::CHAR_ZERO);
   assign is_one     = (item.char_code == prlw_pkg::CHAR_ONE);
   assign zero_match = (cur_zero_ff == first_zero_ff);
   assign one_match  = (cur_one_ff == first_one_ff);

   // Next state, counters and verdict for the word in the input register.
   always_comb begin
      mode_in       = mode_ff;
      first_zero_in = first_zero_ff;
      first_one_in  = first_one_ff;
      cur_zero_in   = cur_zero_ff;
      cur_one_in    = cur_one_ff;
      result        = '0;
      reject_hit    = 1'b0;

      if (fire) begin
         if (word_end) begin
            // Word end or end of stream: give the verdict of the pending word.
            case (mode_cur)
               prlw_pkg::MODE_FIRST_ZERO,
               prlw_pkg::MODE_CHECK_ZERO: begin
                  result.present = 1'b1;
                  result.verdict = 1'b0;
               end
               prlw_pkg::MODE_FIRST_ONE: begin
                  result.present = 1'b1;
                  result.verdict = 1'b1;
               end
               prlw_pkg::MODE_CHECK_ONE: begin
                  result.present = 1'b1;
                  result.verdict = zero_match && one_match;
               end
               default: begin
                  result = '0;
               end
            endcase
            mode_in       = prlw_pkg::MODE_IDLE;
            first_zero_in = '0;
            first_one_in  = '0;
            cur_zero_in   = '0;
            cur_one_in    = '0;
         end else if (mode_cur == prlw_pkg::MODE_SKIP) begin
            // The rest of a rejected word is dropped silently.
            mode_in = prlw_pkg::MODE_SKIP;
         end else if (is_zero) begin
            unique case (mode_cur)
               prlw_pkg::MODE_IDLE: begin
                  first_zero_in = prlw_pkg::COUNT_ONE;
                  first_one_in  = '0;
                  cur_zero_in   = '0;
                  cur_one_in    = '0;
                  mode_in       = prlw_pkg::MODE_FIRST_ZERO;
               end
               prlw_pkg::MODE_FIRST_ZERO: begin
                  first_zero_in = prlw_pkg::sat_inc(first_zero_ff);
               end
               prlw_pkg::MODE_FIRST_ONE: begin
                  cur_zero_in = prlw_pkg::COUNT_ONE;
                  cur_one_in  = '0;
                  mode_in     = prlw_pkg::MODE_CHECK_ZERO;
               end
               prlw_pkg::MODE_CHECK_ZERO: begin
                  cur_zero_in = prlw_pkg::sat_inc(cur_zero_ff);
               end
               prlw_pkg::MODE_CHECK_ONE: begin
                  // A new block starts; the finished one must match the first.
                  if (!(zero_match && one_match)) begin
                     reject_hit = 1'b1;
                  end else begin
                     cur_zero_in = prlw_pkg::COUNT_ONE;
                     cur_one_in  = '0;
                     mode_in     = prlw_pkg::MODE_CHECK_ZERO;
                  end
               end
               default: begin
                  mode_in = mode_cur;
               end
            endcase
         end else if (is_one) begin
            unique case (mode_cur)
               prlw_pkg::MODE_IDLE: begin
                  reject_hit = 1'b1;
               end
               prlw_pkg::MODE_FIRST_ZERO: begin
                  first_one_in = prlw_pkg::COUNT_ONE;
                  mode_in      = prlw_pkg::MODE_FIRST_ONE;
               end
               prlw_pkg::MODE_FIRST_ONE: begin
                  first_one_in = prlw_pkg::sat_inc(first_one_ff);
               end
               prlw_pkg::MODE_CHECK_ZERO: begin
                  if (!zero_match) begin
                     reject_hit = 1'b1;
                  end else begin
                     cur_one_in = prlw_pkg::COUNT_ONE;
                     mode_in    = prlw_pkg::MODE_CHECK_ONE;
                  end
               end
               prlw_pkg::MODE_CHECK_ONE: begin
                  cur_one_in = prlw_pkg::sat_inc(cur_one_ff);
               end
               default: begin
                  mode_in = mode_cur;
               end
            endcase
         end else begin
            // Any other character rejects the word.
            reject_hit = 1'b1;
         end

         if (reject_hit) begin
            result.present = 1'b1;
            result.verdict = 1'b0;
            mode_in        = prlw_pkg::MODE_SKIP;
            first_zero_in  = '0;
            first_one_in   = '0;
            cur_zero_in    = '0;
            cur_one_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= prlw_pkg::MODE_IDLE;
         first_zero_ff <= '0;
         first_one_ff  <= '0;
         cur_zero_ff   <= '0;
         cur_one_ff    <= '0;
      end else begin
         mode_ff       <= mode_in;
         first_zero_ff <= first_zero_in;
         first_one_ff  <= first_one_in;
         cur_zero_ff   <= cur_zero_in;
         cur_one_ff    <= cur_one_in;
      end
   end

   // Between words and while skipping, all run counters are clear.
   `PRLW_ASSERT_IMPLIES(a_idle_clear, clock, reset, (mode_ff == prlw_pkg::MODE_IDLE) || (mode_ff == prlw_pkg::MODE_SKIP), (first_zero_ff == '0) && (first_one_ff == '0) && (cur_zero_ff == '0) && (cur_one_ff == '0))
   // While the first block's ones are counted, both of its runs are nonzero.
   `PRLW_ASSERT_IMPLIES(a_first_block, clock, reset, mode_ff == prlw_pkg::MODE_FIRST_ONE, (first_zero_ff != '0) && (first_one_ff != '0))
   // A later block's zero run starts with no ones counted.
   `PRLW_ASSERT_IMPLIES(a_check_zero, clock, reset, mode_ff == prlw_pkg::MODE_CHECK_ZERO, (cur_zero_ff != '0) && (cur_one_ff == '0))
   // A later block only reaches its ones after its zero run matched the first.
   `PRLW_ASSERT_IMPLIES(a_check_one, clock, reset, mode_ff == prlw_pkg::MODE_CHECK_ONE, (cur_zero_ff == first_zero_ff) && (cur_one_ff != '0))
   // End of stream always returns the scanner to idle.
   `PRLW_ASSERT_NEXT(a_eos_idle, clock, reset, fire && item.end_of_stream, mode_ff == prlw_pkg::MODE_IDLE)

endmodule

FILE: rtl/core/prlw_out_stage.sv
`timescale 1ns / 1ps

module prlw_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  prlw_pkg::result_type result,
   output logic                 slot_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_verdict
);

   logic valid_ff;
   logic valid_in;
   logic verdict_ff;
   logic load;

   // The result register can take a verdict when empty or being drained.
   assign slot_free = !valid_ff || rsp_ready;
   assign load      = fire && result.present;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Verdict payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= result.verdict;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

FILE: rtl/core/periodic_run_length_word_checker.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word contents
// req       in         req_valid/req_ready  req_char_code, req_end_of_stream
// rsp       out        rsp_valid/rsp_ready  rsp_verdict (0 or 1 verdict per input word)
//
// Each input word waits in the input register until it is scanned; its verdict, if any,
// is then registered in the result register.
// Throughput is one word per cycle while the result register is empty or being drained.
// Reset is synchronous and leaves the scanner idle with all run counters clear.
// A stalled rsp channel holds the scanner only when a verdict is still waiting.

module periodic_run_length_word_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_verdict
);

   prlw_pkg::item_type   item;
   prlw_pkg::result_type result;
   logic                 item_valid;
   logic                 slot_free;
   logic                 fire;

   // A word is scanned when present and the result register has room.
   assign fire = item_valid && slot_free;

   prlw_in_stage u_in_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_stream (req_end_of_stream),
      .item              (item),
      .item_valid        (item_valid),
      .item_take         (fire)
   );

   prlw_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   prlw_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .result      (result),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict)
   );

endmodule
